// File: rtl/prba_pkg.sv
`timescale 1ns / 1ps
package prba_pkg;
   localparam int FREE_SLOTS  = 128;
   localparam int GUARD_SLOTS = 16;
   localparam int FIDX_W = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
   localparam int FCNT_W = $clog2(FREE_SLOTS + 1);
   localparam int GIDX_W = (GUARD_SLOTS > 1) ? $clog2(GUARD_SLOTS) : 1;
   localparam int GCNT_W = $clog2(GUARD_SLOTS + 1);
   localparam int ADDR_W = 64;
   localparam int PAGES_W = 52;
   localparam int OP_W = 3;
   localparam int PAGE_SHIFT = 12;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ADDR_W-1:0] PAGE_MASK = 64'h0000_0000_0000_0fff;
   // largest value that still rounds up to a page without wrapping
   localparam logic [ADDR_W-1:0] ROUND_MAX = 64'hffff_ffff_ffff_f000;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR   = 3'd0,
      OP_PROTECT = 3'd1,
      OP_REGION  = 3'd2,
      OP_ALLOC   = 3'd3,
      OP_RELEASE = 3'd4,
      OP_CHECK   = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      CLS_CLEAR, CLS_PROTECT, CLS_REGION, CLS_ALLOC, CLS_RELEASE, CLS_CHECK, CLS_BAD
   } cls_type;

   typedef struct packed {
      cls_type             cls;
      logic [ADDR_W-1:0]   addr;
      logic [ADDR_W-1:0]   ext;
      logic [PAGES_W-1:0]  pages;
      logic [ADDR_W-1:0]   span_end;
      logic                span_bad;
   } work_type;

   typedef struct packed {
      logic [ADDR_W-1:0] fr_start;
      logic [ADDR_W-1:0] fr_end;
      logic [ADDR_W-1:0] fr_cur;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_GINS, ST_GHIT, ST_RGN, ST_RGN_ADV, ST_PIECE,
      ST_FREAD, ST_FEVAL
   } state_type;
endpackage

// File: rtl/prba_if.sv
`timescale 1ns / 1ps
interface prba_req_if;
   import prba_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     opcode;
   logic [ADDR_W-1:0]   address;
   logic [ADDR_W-1:0]   extent;
   logic [PAGES_W-1:0]  page_count;
   modport source (output valid, opcode, address, extent, page_count, input ready);
   modport sink (input valid, opcode, address, extent, page_count, output ready);
endinterface

interface prba_rsp_if;
   import prba_pkg::*;
   logic                valid;
   logic                ready;
   logic                ok;
   logic [ADDR_W-1:0]   base_address;
   logic [PAGES_W-1:0]  free_page_count;
   modport source (output valid, ok, base_address, free_page_count, input ready);
   modport sink (input valid, ok, base_address, free_page_count, output ready);
endinterface

// File: rtl/prba_ram.sv
`timescale 1ns / 1ps
module prba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: rtl/prba_queue.sv
`timescale 1ns / 1ps
module prba_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  prba_pkg::work_type push_data,
   output prba_pkg::hs_type   pop_hs_out,
   input  logic               pop_take,
   output prba_pkg::work_type pop_data
);
   import prba_pkg::*;

   work_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready       = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_hs_out.valid = (count_ff != '0);
   assign pop_hs_out.ready = pop_take;
   assign pop_data         = slot_ff[rd_ptr_ff];
   assign do_push          = push_valid && push_ready;
   assign do_pop           = pop_take && pop_hs_out.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// File: rtl/prba_front.sv
`timescale 1ns / 1ps
module prba_front (
   prba_req_if.sink           req_ch,
   output logic               push_valid,
   input  logic               push_ready,
   output prba_pkg::work_type push_data
);
   import prba_pkg::*;

   logic [ADDR_W:0]   ext_sum;
   logic [ADDR_W:0]   rel_sum;
   logic [ADDR_W-1:0] bytes;

   assign bytes   = {req_ch.page_count, {PAGE_SHIFT{1'b0}}};
   assign ext_sum = {1'b0, req_ch.address} + {1'b0, req_ch.extent};
   assign rel_sum = {1'b0, req_ch.address} + {1'b0, bytes};

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

   always_comb begin
      push_data.addr     = req_ch.address;
      push_data.ext      = req_ch.extent;
      push_data.pages    = req_ch.page_count;
      push_data.span_end = ext_sum[ADDR_W-1:0];
      push_data.span_bad = ext_sum[ADDR_W] || (req_ch.extent == '0);
      push_data.cls      = CLS_BAD;
      unique case (req_ch.opcode)
         OP_CLEAR:   push_data.cls = CLS_CLEAR;
         OP_PROTECT: push_data.cls = CLS_PROTECT;
         OP_REGION:  push_data.cls = CLS_REGION;
         OP_CHECK:   push_data.cls = CLS_CHECK;
         OP_ALLOC: begin
            push_data.cls      = CLS_ALLOC;
            push_data.span_bad = (req_ch.page_count == '0);
         end
         OP_RELEASE: begin
            push_data.cls      = CLS_RELEASE;
            push_data.span_end = rel_sum[ADDR_W-1:0];
            push_data.span_bad = rel_sum[ADDR_W] || (req_ch.page_count == '0);
         end
         default:    push_data.cls = CLS_BAD;
      endcase
   end
endmodule

// File: rtl/prba_back.sv
`timescale 1ns / 1ps
module prba_back (
   input  logic               clock,
   input  logic               reset,
   input  prba_pkg::hs_type   pop_hs_in,
   output logic               pop_take,
   input  prba_pkg::work_type pop_data,
   prba_rsp_if.source         rsp_ch
);
   import prba_pkg::*;

   state_type           state_ff, state_in;
   work_type            cur_ff, cur_in;
   logic [FCNT_W-1:0]   free_used_ff, free_used_in;
   logic [GCNT_W-1:0]   guard_used_ff, guard_used_in;
   logic [PAGES_W-1:0]  pages_free_ff, pages_free_in;
   logic [GCNT_W-1:0]   gp_ff, gp_in;
   logic [FCNT_W-1:0]   fp_ff, fp_in;
   logic [ADDR_W-1:0]   hit_lo_ff, hit_lo_in, hit_hi_ff, hit_hi_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic [ADDR_W-1:0]   pc_a_ff, pc_a_in, pc_b_ff, pc_b_in;
   logic                pc_final_ff, pc_final_in;
   entry_type           ent_ff, ent_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [ADDR_W-1:0]   rsp_base_ff, rsp_base_in;

   logic [ADDR_W-1:0]   gs_ff [GUARD_SLOTS];
   logic [ADDR_W-1:0]   ge_ff [GUARD_SLOTS];
   logic                g_wr;
   logic [ADDR_W-1:0]   g_wr_s, g_wr_e;

   logic                ram_we;
   entry_type           ram_wdata, ram_rdata;
   logic [FIDX_W-1:0]   ram_raddr, ram_waddr;

   // guard table read port: one address per cycle
   logic [GCNT_W-1:0]   g_rd_cnt;
   logic [ADDR_W-1:0]   g_s, g_e;
   logic                g_more, hit_now, rgn_skip, rgn_gap, ins_shift;
   logic                ru_fail, pc_empty, free_full, f_more, a_fit, r_match, pop_ok;
   logic [ADDR_W-1:0]   pc_lo, pc_hi, pc_diff, bytes, ins_hi;
   logic [ADDR_W:0]     a_sum;

   assign g_rd_cnt  = (state_ff == ST_GINS) ? gp_ff - 1'b1 : gp_ff;
   assign g_s       = gs_ff[g_rd_cnt[GIDX_W-1:0]];
   assign g_e       = ge_ff[g_rd_cnt[GIDX_W-1:0]];
   assign g_more    = gp_ff < guard_used_ff;
   assign hit_now   = (hit_lo_ff < g_e) && (g_s < hit_hi_ff);
   assign rgn_skip  = (g_e <= pos_ff) || (g_s >= cur_ff.ext);
   assign rgn_gap   = g_s > pos_ff;
   assign ins_shift = (gp_ff != '0) && (g_s > hit_lo_ff);
   assign ins_hi    = (cur_ff.span_end + PAGE_MASK) & ~PAGE_MASK;

   assign ru_fail   = pc_a_ff > ROUND_MAX;
   assign pc_lo     = (pc_a_ff + PAGE_MASK) & ~PAGE_MASK;
   assign pc_hi     = pc_b_ff & ~PAGE_MASK;
   assign pc_empty  = pc_lo >= pc_hi;
   assign pc_diff   = pc_hi - pc_lo;
   assign free_full = free_used_ff >= FCNT_W'(FREE_SLOTS);

   assign f_more    = fp_ff < free_used_ff;
   assign bytes     = {cur_ff.pages, {PAGE_SHIFT{1'b0}}};
   assign a_sum     = {1'b0, ram_rdata.fr_cur} + {1'b0, bytes};
   assign a_fit     = !a_sum[ADDR_W] && (a_sum[ADDR_W-1:0] <= ram_rdata.fr_end);
   assign r_match   = (cur_ff.addr >= ram_rdata.fr_start) &&
                      (cur_ff.span_end <= ram_rdata.fr_end) &&
                      (cur_ff.span_end == ram_rdata.fr_cur);
   assign pop_ok    = pop_hs_in.valid && (!rsp_valid_ff || rsp_ch.ready);
   assign ram_raddr = fp_ff[FIDX_W-1:0];
   // new pieces go to the end of the table, bumps go back to the entry just read
   assign ram_waddr = (state_ff == ST_PIECE) ? free_used_ff[FIDX_W-1:0] : fp_ff[FIDX_W-1:0];

   prba_ram #(.WIDTH(ENTRY_W), .DEPTH(FREE_SLOTS)) u_free_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (pop_ok) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            unique case (cur_ff.cls)
               CLS_PROTECT: begin
                  if (!(cur_ff.span_bad || guard_used_ff >= GCNT_W'(GUARD_SLOTS) ||
                        cur_ff.span_end > ROUND_MAX)) state_in = ST_GINS;
                  else state_in = ST_IDLE;
               end
               CLS_CHECK:   state_in = cur_ff.span_bad ? ST_IDLE : ST_GHIT;
               CLS_REGION:  state_in = ST_RGN;
               CLS_ALLOC,
               CLS_RELEASE: state_in = cur_ff.span_bad ? ST_IDLE : ST_FREAD;
               default:     state_in = ST_IDLE;
            endcase
         end
         ST_GINS: if (!ins_shift) state_in = ST_IDLE;
         ST_GHIT: if (!g_more || hit_now) state_in = ST_IDLE;
         ST_RGN: begin
            priority if (!g_more) state_in = ST_PIECE;
            else if (rgn_skip)    state_in = ST_RGN;
            else if (rgn_gap)     state_in = ST_PIECE;
            else                  state_in = ST_RGN_ADV;
         end
         ST_RGN_ADV: state_in = (g_e >= cur_ff.ext) ? ST_IDLE : ST_RGN;
         ST_PIECE: begin
            priority if (ru_fail || (!pc_empty && free_full)) state_in = ST_IDLE;
            else if (pc_final_ff)                             state_in = ST_IDLE;
            else                                              state_in = ST_RGN_ADV;
         end
         ST_FREAD: state_in = f_more ? ST_FEVAL : ST_IDLE;
         ST_FEVAL: begin
            if (cur_ff.cls == CLS_ALLOC) state_in = a_fit ? ST_GHIT : ST_FREAD;
            else                         state_in = r_match ? ST_IDLE : ST_FREAD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      cur_in        = cur_ff;
      free_used_in  = free_used_ff;
      guard_used_in = guard_used_ff;
      pages_free_in = pages_free_ff;
      gp_in         = gp_ff;
      fp_in         = fp_ff;
      hit_lo_in     = hit_lo_ff;
      hit_hi_in     = hit_hi_ff;
      pos_in        = pos_ff;
      pc_a_in       = pc_a_ff;
      pc_b_in       = pc_b_ff;
      pc_final_in   = pc_final_ff;
      ent_in        = ent_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      pop_take      = 1'b0;
      g_wr          = 1'b0;
      g_wr_s        = hit_lo_ff;
      g_wr_e        = hit_hi_ff;
      ram_we        = 1'b0;
      ram_wdata     = ent_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_ok) begin
               pop_take = 1'b1;
               cur_in   = pop_data;
            end
         end
         ST_DISPATCH: begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b0;
            rsp_base_in  = '0;
            gp_in        = '0;
            fp_in        = '0;
            hit_lo_in    = cur_ff.addr;
            hit_hi_in    = cur_ff.span_end;
            pos_in       = cur_ff.addr;
            unique case (cur_ff.cls)
               CLS_CLEAR: begin
                  free_used_in  = '0;
                  guard_used_in = '0;
                  pages_free_in = '0;
                  rsp_ok_in     = 1'b1;
               end
               CLS_PROTECT: begin
                  gp_in     = guard_used_ff;
                  hit_lo_in = cur_ff.addr & ~PAGE_MASK;
                  hit_hi_in = ins_hi;
                  if (!(cur_ff.span_bad || guard_used_ff >= GCNT_W'(GUARD_SLOTS) ||
                        cur_ff.span_end > ROUND_MAX)) rsp_valid_in = 1'b0;
               end
               CLS_CHECK, CLS_ALLOC, CLS_RELEASE: begin
                  if (!cur_ff.span_bad) rsp_valid_in = 1'b0;
               end
               CLS_REGION: rsp_valid_in = 1'b0;
               default: ;
            endcase
         end
         ST_GINS: begin
            g_wr = 1'b1;
            if (ins_shift) begin
               g_wr_s = g_s;
               g_wr_e = g_e;
               gp_in  = gp_ff - 1'b1;
            end else begin
               guard_used_in = guard_used_ff + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_ok_in     = 1'b1;
            end
         end
         ST_GHIT: begin
            if (!g_more || hit_now) begin
               rsp_valid_in = 1'b1;
               if (cur_ff.cls == CLS_CHECK) begin
                  rsp_ok_in = hit_now && g_more;
               end else if (!g_more) begin
                  // span is clear of every protected range: commit the bump
                  ram_we           = 1'b1;
                  ram_wdata.fr_cur = hit_hi_ff;
                  rsp_ok_in        = 1'b1;
                  rsp_base_in      = hit_lo_ff;
                  pages_free_in    = pages_free_ff - cur_ff.pages;
               end
            end else begin
               gp_in = gp_ff + 1'b1;
            end
         end
         ST_RGN: begin
            priority if (!g_more) begin
               pc_a_in     = pos_ff;
               pc_b_in     = cur_ff.ext;
               pc_final_in = 1'b1;
            end else if (rgn_skip) begin
               gp_in = gp_ff + 1'b1;
            end else if (rgn_gap) begin
               pc_a_in     = pos_ff;
               pc_b_in     = g_s;
               pc_final_in = 1'b0;
            end else begin
               pc_final_in = 1'b0;
            end
         end
         ST_RGN_ADV: begin
            pos_in = g_e;
            gp_in  = gp_ff + 1'b1;
            if (g_e >= cur_ff.ext) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
            end
         end
         ST_PIECE: begin
            if (ru_fail || (!pc_empty && free_full)) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
            end else begin
               if (!pc_empty) begin
                  ram_we             = 1'b1;
                  ram_wdata.fr_start = pc_lo;
                  ram_wdata.fr_end   = pc_hi;
                  ram_wdata.fr_cur   = pc_lo;
                  free_used_in       = free_used_ff + 1'b1;
                  pages_free_in      = pages_free_ff + pc_diff[ADDR_W-1:PAGE_SHIFT];
               end
               if (pc_final_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b1;
               end
            end
         end
         ST_FREAD: begin
            if (!f_more) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
            end
         end
         ST_FEVAL: begin
            ent_in = ram_rdata;
            if (cur_ff.cls == CLS_ALLOC) begin
               if (a_fit) begin
                  hit_lo_in = ram_rdata.fr_cur;
                  hit_hi_in = a_sum[ADDR_W-1:0];
                  gp_in     = '0;
               end else begin
                  fp_in = fp_ff + 1'b1;
               end
            end else if (r_match) begin
               ram_we           = 1'b1;
               ram_wdata        = ram_rdata;
               ram_wdata.fr_cur = cur_ff.addr;
               pages_free_in    = pages_free_ff + cur_ff.pages;
               rsp_valid_in     = 1'b1;
               rsp_ok_in        = 1'b1;
            end else begin
               fp_in = fp_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.ok              = rsp_ok_ff;
   assign rsp_ch.base_address    = rsp_base_ff;
   assign rsp_ch.free_page_count = pages_free_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_used_ff  <= '0;
         guard_used_ff <= '0;
         pages_free_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_used_ff  <= free_used_in;
         guard_used_ff <= guard_used_in;
         pages_free_ff <= pages_free_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      gp_ff       <= gp_in;
      fp_ff       <= fp_in;
      hit_lo_ff   <= hit_lo_in;
      hit_hi_ff   <= hit_hi_in;
      pos_ff      <= pos_in;
      pc_a_ff     <= pc_a_in;
      pc_b_ff     <= pc_b_in;
      pc_final_ff <= pc_final_in;
      ent_ff      <= ent_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_base_ff <= rsp_base_in;
      if (g_wr) begin
         gs_ff[gp_ff[GIDX_W-1:0]] <= g_wr_s;
         ge_ff[gp_ff[GIDX_W-1:0]] <= g_wr_e;
      end
   end
endmodule

// File: rtl/protected_range_bump_page_allocator.sv
// Page allocator for 4 KiB pages over a table of free ranges with bump
// cursors and a start-sorted table of protected ranges.
// Channels: req_ch carries one operation per transfer (opcode, address,
// extent, page_count); rsp_ch returns exactly one result per operation
// (ok, base_address, free_page_count) in request order.
// A two-entry queue sits between the request side and the sequencer, so
// requests are taken while an operation is being worked on.
// From queue head to result: clear and unknown opcodes are answered in
// dispatch; add protected shifts the entries above the new start; check
// protected walks the protected entries up to the first hit; add region
// walks them and writes the pieces between; allocate and release visit
// free entries (registered read of the free-range RAM), plus the
// protected walk for allocate. The sequencer takes one operation at a time.
// Reset clears the entry counts and the page total; no clearing pass is run,
// the block accepts requests as soon as reset is released.
// When the receiver stalls, the result holds on rsp_ch and the sequencer
// waits; requests keep filling the queue until it is full.
`timescale 1ns / 1ps
module protected_range_bump_page_allocator (
   input  logic      clock,
   input  logic      reset,
   prba_req_if.sink  req_ch,
   prba_rsp_if.source rsp_ch
);
   import prba_pkg::*;

   logic     push_valid, push_ready, pop_take;
   work_type push_data, pop_data;
   hs_type   pop_hs;

   prba_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   prba_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_hs_out (pop_hs),
      .pop_take   (pop_take),
      .pop_data   (pop_data)
   );

   prba_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_hs_in (pop_hs),
      .pop_take  (pop_take),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );
endmodule

// File: rtl/prba_checker.sv
`timescale 1ns / 1ps
module prba_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_ok,
   input logic [prba_pkg::ADDR_W-1:0]  rsp_base,
   input logic [prba_pkg::PAGES_W-1:0] rsp_pages
);
   import prba_pkg::*;

   // no result can come out of reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result valid right after reset");

   // a base address is only reported by a successful allocation
   a_base_needs_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_base != '0) |-> rsp_ok) else $error("base without success");

   // no result follows a transfer until the next operation is dispatched
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid) else $error("result straight after transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_ok) &&
      $stable(rsp_base) && $stable(rsp_pages))) else $error("stalled result changed");
endmodule

bind protected_range_bump_page_allocator prba_checker u_prba_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_ok    (rsp_ch.ok),
   .rsp_base  (rsp_ch.base_address),
   .rsp_pages (rsp_ch.free_page_count)
);

// File: sim/tb_protected_range_bump_page_allocator.sv
`timescale 1ns / 1ps
module tb_protected_range_bump_page_allocator;
   import prba_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
   localparam logic [ADDR_W-1:0] WIN_BASE = 64'h0000_0008_0000_0000;
   localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
   localparam int CYCLE_LIMIT = 3_000_000;

   typedef struct {
      bit                ok;
      bit [ADDR_W-1:0]   base;
      bit [PAGES_W-1:0]  pages;
   } alloc_rsp_type;

   typedef struct {
      bit [ADDR_W-1:0]   base;
      bit [PAGES_W-1:0]  pages;
   } grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   prba_req_if req_ch ();
   prba_rsp_if rsp_ch ();

   protected_range_bump_page_allocator uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   // predicted allocator state
   bit [ADDR_W-1:0]  rng_start [FREE_SLOTS];
   bit [ADDR_W-1:0]  rng_end [FREE_SLOTS];
   bit [ADDR_W-1:0]  rng_cur [FREE_SLOTS];
   int               rng_used;
   bit [ADDR_W-1:0]  prot_start [GUARD_SLOTS];
   bit [ADDR_W-1:0]  prot_end [GUARD_SLOTS];
   int               prot_used;
   bit [PAGES_W-1:0] pages_left;

   alloc_rsp_type pending_rsp [$];
   grant_type     grants [$];
   int         mismatches;
   int         rsp_seen;
   int         op_sent [8];
   int         ok_seen;
   int         cycles;
   bit         no_idle;
   int         hold_request;
   int         hold_cnt;

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.opcode     = OP_CLEAR;
      req_ch.address    = '0;
      req_ch.extent     = '0;
      req_ch.page_count = '0;
      rsp_ch.ready      = 1'b0;
   end

   function automatic bit add_fits(input bit [ADDR_W-1:0] a, input bit [ADDR_W-1:0] b,
                                   output bit [ADDR_W-1:0] s);
      bit [ADDR_W:0] wide;
      wide = {1'b0, a} + {1'b0, b};
      s = wide[ADDR_W-1:0];
      return !wide[ADDR_W];
   endfunction

   function automatic bit page_ceil(input bit [ADDR_W-1:0] v, output bit [ADDR_W-1:0] r);
      if (v > ROUND_MAX) return 1'b0;
      r = (v + PAGE_MASK) & ~PAGE_MASK;
      return 1'b1;
   endfunction

   function automatic bit hits_protected(input bit [ADDR_W-1:0] s, input bit [ADDR_W-1:0] e);
      for (int i = 0; i < prot_used; i++)
         if (s < prot_end[i] && prot_start[i] < e) return 1'b1;
      return 1'b0;
   endfunction

   function automatic bit protect_range(input bit [ADDR_W-1:0] s, input bit [ADDR_W-1:0] sz);
      bit [ADDR_W-1:0] e, lo, hi;
      int j;
      if (sz == 0 || !add_fits(s, sz, e) || e <= s) return 1'b0;
      if (prot_used >= GUARD_SLOTS) return 1'b0;
      lo = s & ~PAGE_MASK;
      if (!page_ceil(e, hi) || hi <= lo) return 1'b0;
      j = prot_used;
      while (j != 0 && prot_start[j-1] > lo) begin
         prot_start[j] = prot_start[j-1];
         prot_end[j] = prot_end[j-1];
         j--;
      end
      prot_start[j] = lo;
      prot_end[j] = hi;
      prot_used++;
      return 1'b1;
   endfunction

   function automatic bit append_piece(input bit [ADDR_W-1:0] s, input bit [ADDR_W-1:0] e);
      bit [ADDR_W-1:0] lo, hi;
      if (!page_ceil(s, lo)) return 1'b0;
      hi = e & ~PAGE_MASK;
      if (lo >= hi) return 1'b1;
      if (rng_used >= FREE_SLOTS) return 1'b0;
      rng_start[rng_used] = lo;
      rng_end[rng_used] = hi;
      rng_cur[rng_used] = lo;
      pages_left += PAGES_W'((hi - lo) >> PAGE_SHIFT);
      rng_used++;
      return 1'b1;
   endfunction

   function automatic bit add_free_region(input bit [ADDR_W-1:0] s, input bit [ADDR_W-1:0] e);
      bit [ADDR_W-1:0] pos;
      pos = s;
      for (int i = 0; i < prot_used; i++) begin
         if (prot_end[i] <= pos || prot_start[i] >= e) continue;
         if (prot_start[i] > pos && !append_piece(pos, prot_start[i])) return 1'b0;
         if (prot_end[i] > pos) pos = prot_end[i];
         if (pos >= e) return 1'b1;
      end
      return append_piece(pos, e);
   endfunction

   function automatic bit take_pages(input bit [PAGES_W-1:0] n, output bit [ADDR_W-1:0] b);
      bit [ADDR_W-1:0] bytes, e;
      b = '0;
      if (n == 0) return 1'b0;
      bytes = {n, 12'h000};
      for (int i = 0; i < rng_used; i++) begin
         if (!add_fits(rng_cur[i], bytes, e) || e > rng_end[i]) continue;
         if (hits_protected(rng_cur[i], e)) return 1'b0;
         b = rng_cur[i];
         rng_cur[i] = e;
         pages_left -= n;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit give_back(input bit [ADDR_W-1:0] b, input bit [PAGES_W-1:0] n);
      bit [ADDR_W-1:0] e;
      if (n == 0 || !add_fits(b, {n, 12'h000}, e)) return 1'b0;
      for (int i = 0; i < rng_used; i++) begin
         if (b >= rng_start[i] && e <= rng_end[i] && e == rng_cur[i]) begin
            rng_cur[i] = b;
            pages_left += n;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic alloc_rsp_type predict_alloc(input logic [OP_W-1:0] op,
                                                   input bit [ADDR_W-1:0] a,
                                                   input bit [ADDR_W-1:0] x,
                                                   input bit [PAGES_W-1:0] n);
      alloc_rsp_type r;
      bit [ADDR_W-1:0] e;
      r.ok = 1'b0;
      r.base = '0;
      case (op)
         OP_CLEAR: begin
            rng_used = 0;
            prot_used = 0;
            pages_left = '0;
            r.ok = 1'b1;
         end
         OP_PROTECT: r.ok = protect_range(a, x);
         OP_REGION:  r.ok = add_free_region(a, x);
         OP_ALLOC:   r.ok = take_pages(n, r.base);
         OP_RELEASE: r.ok = give_back(a, n);
         OP_CHECK:   r.ok = add_fits(a, x, e) && e > a && hits_protected(a, e);
         default:    r.ok = 1'b0;
      endcase
      r.pages = pages_left;
      return r;
   endfunction

   task automatic send_op(input logic [OP_W-1:0] op, input bit [ADDR_W-1:0] a,
                          input bit [ADDR_W-1:0] x, input bit [PAGES_W-1:0] n);
      alloc_rsp_type r;
      r = predict_alloc(op, a, x, n);
      pending_rsp.push_back(r);
      op_sent[op]++;
      if (op == OP_ALLOC && r.ok) grants.push_back('{r.base, n});
      if (op == OP_RELEASE && r.ok && grants.size() > 0 &&
          grants[$].base == a && grants[$].pages == n)
         void'(grants.pop_back());
      if (op == OP_CLEAR) grants.delete();
      req_ch.valid      <= 1'b1;
      req_ch.opcode     <= op;
      req_ch.address    <= a;
      req_ch.extent     <= x;
      req_ch.page_count <= n;
      do @(posedge clock); while (!req_ch.ready);
      if (!no_idle && $urandom_range(99) < 10) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
         end else begin
            alloc_rsp_type r;
            r = pending_rsp.pop_front();
            if (rsp_ch.ok) ok_seen++;
            if (rsp_ch.ok !== r.ok || rsp_ch.base_address !== r.base ||
                rsp_ch.free_page_count !== r.pages) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch #%0d: ok %0b/%0b base %h/%h pages %h/%h (exp/act)",
                           rsp_seen, r.ok, rsp_ch.ok, r.base, rsp_ch.base_address,
                           r.pages, rsp_ch.free_page_count);
            end
         end
      end
   end

   // result side: random back-pressure plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_cnt <= 0;
      end else if (hold_request > 0) begin
         hold_cnt <= hold_request;
         hold_request = 0;
         rsp_ch.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= no_idle || $urandom_range(99) >= 10;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_rsp.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic bit [ADDR_W-1:0] any64();
      return {$urandom, $urandom};
   endfunction

   function automatic bit [ADDR_W-1:0] win_addr();
      bit [ADDR_W-1:0] a;
      a = WIN_BASE + (ADDR_W'($urandom_range(0, 1023)) << PAGE_SHIFT);
      if ($urandom_range(3) == 0) a += ADDR_W'($urandom_range(1, 4095));
      return a;
   endfunction

   task automatic test_clear_and_spare_ops();
      send_op(OP_CLEAR, '0, '0, '0);
      send_op(OP_SPARE_LO, ADDR_MAX, ADDR_MAX, '1);
      send_op(OP_SPARE_HI, '0, '0, '0);
   endtask

   task automatic test_protect_edges();
      send_op(OP_PROTECT, WIN_BASE, '0, '0);                     // zero size
      send_op(OP_PROTECT, ADDR_MAX, 64'd2, '0);                  // end wraps
      send_op(OP_PROTECT, ROUND_MAX, 64'h800, '0);               // end cannot round up
      send_op(OP_PROTECT, WIN_BASE + 64'h5123, 64'h10, '0);      // widened both ways
      send_op(OP_PROTECT, WIN_BASE + 64'h2000, 64'h1000, '0);    // inserted ahead
      send_op(OP_PROTECT, WIN_BASE + 64'h2000, 64'h3000, '0);    // equal start
   endtask

   task automatic test_region_edges();
      send_op(OP_REGION, ROUND_MAX + 64'd1, ADDR_MAX, '0);       // start cannot round up
      send_op(OP_REGION, WIN_BASE + 64'h10, WIN_BASE + 64'hff0, '0); // empty piece
      send_op(OP_REGION, WIN_BASE, WIN_BASE + 64'h10000, '0);    // cut around guards
      send_op(OP_REGION, WIN_BASE + 64'h2800, WIN_BASE + 64'h4000, '0); // inside a guard
   endtask

   task automatic test_alloc_release();
      send_op(OP_ALLOC, '0, '0, '0);                             // zero pages
      send_op(OP_ALLOC, '0, '0, '1);                             // too large
      send_op(OP_ALLOC, '0, '0, 52'd2);                          // taken from the first free range
      send_op(OP_RELEASE, ADDR_MAX, '0, 52'd1);                  // span wraps
      send_op(OP_RELEASE, WIN_BASE, '0, '0);                     // zero pages
      send_op(OP_CLEAR, '0, '0, '0);
      send_op(OP_REGION, WIN_BASE, WIN_BASE + 64'h8000, '0);
      send_op(OP_ALLOC, '0, '0, 52'd2);
      send_op(OP_ALLOC, '0, '0, 52'd3);
      send_op(OP_RELEASE, WIN_BASE, '0, 52'd2);                  // not the latest
      send_op(OP_RELEASE, WIN_BASE + 64'h2000, '0, 52'd3);       // latest goes back
      send_op(OP_RELEASE, WIN_BASE, '0, 52'd2);
   endtask

   task automatic test_check();
      send_op(OP_PROTECT, WIN_BASE + 64'h3000, 64'h1000, '0);
      send_op(OP_CHECK, WIN_BASE + 64'h3fff, 64'd1, '0);
      send_op(OP_CHECK, WIN_BASE + 64'h4000, 64'h1000, '0);
      send_op(OP_CHECK, WIN_BASE, '0, '0);
      send_op(OP_CHECK, ADDR_MAX, ADDR_MAX, '0);
   endtask

   task automatic test_fill_tables();
      send_op(OP_CLEAR, '0, '0, '0);
      for (int i = 0; i <= GUARD_SLOTS; i++)
         send_op(OP_PROTECT, WIN_BASE + 64'h10_0000 + (ADDR_W'(i) << 13), 64'h1000, '0);
      for (int i = 0; i <= FREE_SLOTS; i++)
         send_op(OP_REGION, WIN_BASE + (ADDR_W'(i) << 13),
                 WIN_BASE + (ADDR_W'(i) << 13) + 64'h1000, '0);
      send_op(OP_ALLOC, '0, '0, 52'd1);
   endtask

   task automatic test_stall_pressure();
      bit keep;
      keep = no_idle;
      no_idle = 1'b1;
      hold_request = 400;
      for (int i = 0; i < 30; i++) send_op(OP_CHECK, win_addr(), 64'h3000, '0);
      no_idle = keep;
   endtask

   task automatic test_random_ops(input int n);
      int pick;
      bit [ADDR_W-1:0] a;
      for (int i = 0; i < n; i++) begin
         no_idle = (i >= n / 3 && i < n / 2);
         pick = $urandom_range(999);
         a = win_addr();
         if (pick < 4)
            send_op(OP_CLEAR, any64(), any64(), PAGES_W'(any64()));
         else if (pick < 120)
            send_op(OP_PROTECT, a, ADDR_W'($urandom_range(1, 32'h6000)), '0);
         else if (pick < 350)
            send_op(OP_REGION, a, a + (ADDR_W'($urandom_range(0, 64)) << PAGE_SHIFT) +
                    ADDR_W'($urandom_range(0, 4095)), '0);
         else if (pick < 620) begin
            if ($urandom_range(19) == 0)
               send_op(OP_ALLOC, '0, '0, PAGES_W'(any64()));
            else
               send_op(OP_ALLOC, '0, '0, PAGES_W'($urandom_range(0, 16)));
         end else if (pick < 850) begin
            if (grants.size() > 0 && $urandom_range(9) < 7)
               send_op(OP_RELEASE, grants[$].base, '0, grants[$].pages);
            else if (grants.size() > 0)
               send_op(OP_RELEASE, grants[0].base, '0, PAGES_W'($urandom_range(0, 4)));
            else
               send_op(OP_RELEASE, a, '0, PAGES_W'($urandom_range(0, 4)));
         end else if (pick < 950)
            send_op(OP_CHECK, a, ADDR_W'($urandom_range(0, 32'h8000)), '0);
         else
            send_op(OP_W'($urandom_range(0, 7)), any64(), any64(), PAGES_W'(any64()));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_clear_and_spare_ops();
      test_protect_edges();
      test_region_edges();
      test_alloc_release();
      test_check();
      test_fill_tables();
      test_stall_pressure();
      test_random_ops(1550);
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("%0d operations checked: clear %0d protect %0d region %0d alloc %0d",
               rsp_seen, op_sent[OP_CLEAR], op_sent[OP_PROTECT], op_sent[OP_REGION],
               op_sent[OP_ALLOC]);
      $display("release %0d check %0d spare %0d, %0d succeeded, %0d mismatches",
               op_sent[OP_RELEASE], op_sent[OP_CHECK],
               op_sent[OP_SPARE_LO] + op_sent[OP_SPARE_HI], ok_seen, mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

// File: sim.f
rtl/prba_pkg.sv
rtl/prba_if.sv
rtl/prba_ram.sv
rtl/prba_queue.sv
rtl/prba_front.sv
rtl/prba_back.sv
rtl/protected_range_bump_page_allocator.sv
rtl/prba_checker.sv
sim/tb_protected_range_bump_page_allocator.sv
